>>> rtl/vda_pkg.sv
package vda_pkg;

   localparam int SUM_BITS      = 28;
   localparam int CNT_BITS      = 13;
   localparam int AXIS_BITS     = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int MUL_IDX_BITS  = $clog2(SUM_BITS);

   localparam int DEF_MAX_HITS    = 4096;
   localparam int DEF_POS_BITS    = 20;
   localparam int DEF_ENERGY_BITS = 16;
   localparam int DEF_FRAC_BITS   = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_USE_ENERGY = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_VERTEX_X   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_VERTEX_Z   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_AXIS_X     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_AXIS_Z     = 3'd4;

   localparam logic [1:0] STAT_ENERGY   = 2'd0;
   localparam logic [1:0] STAT_HITS     = 2'd1;
   localparam logic [1:0] STAT_DEGEN    = 2'd2;
   localparam logic [1:0] STAT_NO_HITS  = 2'd3;

   typedef struct packed {
      logic                    accept;
      logic                    clear;
      logic                    capture;
      logic                    select;
      logic                    mul_step;
      logic                    mul_sel;
      logic                    mul_last;
      logic [MUL_IDX_BITS-1:0] mul_idx;
      logic                    div_load;
      logic                    div_step;
   } cmd_type;

   typedef struct packed {
      logic last_pending;
      logic ratio;
   } stat_type;

endpackage

>>> rtl/vda_ctrl.sv
module vda_ctrl #(
   parameter int FRAC_BITS = vda_pkg::DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  vda_pkg::stat_type  stat,
   output vda_pkg::cmd_type   cmd
);

   localparam int STEPS = (vda_pkg::SUM_BITS > FRAC_BITS + 1) ?
                          vda_pkg::SUM_BITS : FRAC_BITS + 1;
   localparam int CW = $clog2(STEPS);

   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_CAPT  = 3'd1;
   localparam logic [2:0] ST_SEL   = 3'd2;
   localparam logic [2:0] ST_MULA  = 3'd3;
   localparam logic [2:0] ST_MULB  = 3'd4;
   localparam logic [2:0] ST_DLOAD = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;

   assign req_stall = (state_ff != ST_RUN) | stat.last_pending;
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd = '0;
      cmd.mul_idx = count_ff[vda_pkg::MUL_IDX_BITS-1:0];
      unique case (state_ff)
         ST_RUN: begin
            cmd.accept = req_valid & ~req_stall;
            if (stat.last_pending) state_in = ST_CAPT;
         end
         ST_CAPT: begin
            cmd.capture = 1'b1;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.select = 1'b1;
            count_in = CW'(vda_pkg::SUM_BITS - 1);
            state_in = stat.ratio ? ST_MULA : ST_OUT;
         end
         ST_MULA, ST_MULB: begin
            cmd.mul_step = 1'b1;
            cmd.mul_sel  = (state_ff == ST_MULB);
            cmd.mul_last = (count_ff == '0);
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               count_in = CW'(vda_pkg::SUM_BITS - 1);
               state_in = (state_ff == ST_MULA) ? ST_MULB : ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            count_in = CW'(FRAC_BITS);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               cmd.clear = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/vda_datapath.sv
module vda_datapath #(
   parameter int MAX_HITS    = vda_pkg::DEF_MAX_HITS,
   parameter int POS_BITS    = vda_pkg::DEF_POS_BITS,
   parameter int ENERGY_BITS = vda_pkg::DEF_ENERGY_BITS,
   parameter int FRAC_BITS   = vda_pkg::DEF_FRAC_BITS,
   parameter int CSR_BITS    = (POS_BITS > vda_pkg::AXIS_BITS) ? POS_BITS : vda_pkg::AXIS_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [vda_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CSR_BITS-1:0]                 csr_data,
   input  logic                                req_hit_present,
   input  logic signed [POS_BITS-1:0]          req_hit_x,
   input  logic signed [POS_BITS-1:0]          req_hit_z,
   input  logic [ENERGY_BITS-1:0]              req_hit_energy,
   input  logic                                req_last_hit,
   output logic [FRAC_BITS:0]                  rsp_asymmetry,
   output logic [1:0]                          rsp_status,
   input  vda_pkg::cmd_type                    cmd,
   output vda_pkg::stat_type                   stat
);

   localparam int SB  = vda_pkg::SUM_BITS;
   localparam int CB  = vda_pkg::CNT_BITS;
   localparam int AB  = vda_pkg::AXIS_BITS;
   localparam int PB  = POS_BITS + 18;
   localparam int MB  = POS_BITS + 17;
   localparam int EW  = ((ENERGY_BITS > SB) ? ENERGY_BITS : SB) + 1;
   localparam int TW  = SB + PB;
   localparam int RW  = TW + 1 + FRAC_BITS;
   localparam logic [SB-1:0] SUM_MAX = {SB{1'b1}};
   localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
   localparam logic signed [PB-1:0] P_MAX = {1'b0, {(PB-1){1'b1}}};
   localparam logic signed [PB-1:0] P_MIN = {1'b1, {(PB-1){1'b0}}};

   // configuration
   logic                       use_energy_ff;
   logic signed [POS_BITS-1:0] vx_ff, vz_ff;
   logic signed [AB-1:0]       ax_ff, az_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_energy_ff <= 1'b1;
         vx_ff <= '0;
         vz_ff <= '0;
         ax_ff <= '0;
         az_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            vda_pkg::REG_USE_ENERGY: use_energy_ff <= csr_data[0];
            vda_pkg::REG_VERTEX_X:   vx_ff <= csr_data[POS_BITS-1:0];
            vda_pkg::REG_VERTEX_Z:   vz_ff <= csr_data[POS_BITS-1:0];
            vda_pkg::REG_AXIS_X:     ax_ff <= csr_data[AB-1:0];
            vda_pkg::REG_AXIS_Z:     az_ff <= csr_data[AB-1:0];
            default: ;
         endcase
      end
   end

   // stage one: offsets and products
   logic signed [POS_BITS:0] dx, dz;
   logic signed [MB-1:0]     px, pz;
   logic signed [MB-1:0]     px_ff, pz_ff;
   logic                     s1_valid_ff, s1_present_ff, s1_last_ff;
   logic [ENERGY_BITS-1:0]   s1_energy_ff;

   assign dx = (POS_BITS+1)'(req_hit_x) - (POS_BITS+1)'(vx_ff);
   assign dz = (POS_BITS+1)'(req_hit_z) - (POS_BITS+1)'(vz_ff);
   assign px = MB'(dx) * MB'(ax_ff);
   assign pz = MB'(dz) * MB'(az_ff);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= cmd.accept;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff <= px;
         pz_ff <= pz;
         s1_present_ff <= req_hit_present;
         s1_last_ff    <= req_last_hit;
         s1_energy_ff  <= req_hit_energy;
      end
   end

   assign stat.last_pending = s1_valid_ff & s1_last_ff;

   // stage two: side accumulators
   logic [SB-1:0]        bsum_ff, asum_ff;
   logic [CB-1:0]        bcnt_ff, acnt_ff;
   logic signed [PB-1:0] bmin_ff, bmax_ff, amin_ff, amax_ff;
   logic signed [PB-1:0] proj;
   logic                 take, to_before;
   logic [EW-1:0]        bsum_w, asum_w;

   assign proj      = PB'(px_ff) + PB'(pz_ff);
   assign to_before = proj[PB-1];
   assign take   = s1_valid_ff & s1_present_ff &
                   ((32'(bcnt_ff) + 32'(acnt_ff)) < 32'(MAX_HITS));
   assign bsum_w = EW'(bsum_ff) + EW'(s1_energy_ff);
   assign asum_w = EW'(asum_ff) + EW'(s1_energy_ff);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         bsum_ff <= '0;
         asum_ff <= '0;
         bcnt_ff <= '0;
         acnt_ff <= '0;
         bmin_ff <= P_MAX;
         amin_ff <= P_MAX;
         bmax_ff <= P_MIN;
         amax_ff <= P_MIN;
      end else if (take) begin
         if (to_before) begin
            if (proj < bmin_ff) bmin_ff <= proj;
            if (proj > bmax_ff) bmax_ff <= proj;
            bsum_ff <= (bsum_w > EW'(SUM_MAX)) ? SUM_MAX : bsum_w[SB-1:0];
            if (bcnt_ff != CNT_MAX) bcnt_ff <= bcnt_ff + 1'b1;
         end else begin
            if (proj < amin_ff) amin_ff <= proj;
            if (proj > amax_ff) amax_ff <= proj;
            asum_ff <= (asum_w > EW'(SUM_MAX)) ? SUM_MAX : asum_w[SB-1:0];
            if (acnt_ff != CNT_MAX) acnt_ff <= acnt_ff + 1'b1;
         end
      end
   end

   // lengths and metric choice
   logic [PB-1:0] la_ff, lb_ff;
   logic          e_live, h_live;
   logic [1:0]    code;
   logic [1:0]    status_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         la_ff <= (acnt_ff != '0) ? PB'(amax_ff - amin_ff) : '0;
         lb_ff <= (bcnt_ff != '0) ? PB'(bmax_ff - bmin_ff) : '0;
      end
   end

   always_comb begin
      e_live = ((la_ff != '0) && (asum_ff != '0)) || ((lb_ff != '0) && (bsum_ff != '0));
      h_live = ((la_ff != '0) && (acnt_ff != '0)) || ((lb_ff != '0) && (bcnt_ff != '0));
      priority if (use_energy_ff && e_live)        code = vda_pkg::STAT_ENERGY;
      else if ((bcnt_ff == '0) && (acnt_ff == '0)) code = vda_pkg::STAT_NO_HITS;
      else if (h_live)                             code = vda_pkg::STAT_HITS;
      else                                         code = vda_pkg::STAT_DEGEN;
   end

   assign stat.ratio = (code == vda_pkg::STAT_ENERGY) || (code == vda_pkg::STAT_HITS);

   // cross-weighted terms, one multiplier bit a cycle
   logic [SB-1:0] va_ff, vb_ff;
   logic [PB-1:0] ma_ff, mb_ff;
   logic [TW-1:0] acc_ff, acc_in, ta_ff, tb_ff;
   logic          mbit;

   assign mbit   = cmd.mul_sel ? vb_ff[cmd.mul_idx] : va_ff[cmd.mul_idx];
   assign acc_in = {acc_ff[TW-2:0], 1'b0} +
                   (mbit ? TW'(cmd.mul_sel ? mb_ff : ma_ff) : '0);

   // quotient, one bit a cycle
   logic [RW-1:0]    rem_ff, d_ff;
   logic [FRAC_BITS:0] q_ff;
   logic [TW-1:0]    num;
   logic [TW:0]      den;

   assign num = (ta_ff >= tb_ff) ? (ta_ff - tb_ff) : (tb_ff - ta_ff);
   assign den = (TW+1)'(ta_ff) + (TW+1)'(tb_ff);

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         status_ff <= code;
         q_ff      <= '0;
         acc_ff    <= '0;
         if (code == vda_pkg::STAT_ENERGY) begin
            va_ff <= asum_ff;
            vb_ff <= bsum_ff;
         end else begin
            va_ff <= SB'(acnt_ff);
            vb_ff <= SB'(bcnt_ff);
         end
         ma_ff <= (la_ff != '0) ? ((lb_ff != '0) ? lb_ff : PB'(1)) : '0;
         mb_ff <= (lb_ff != '0) ? ((la_ff != '0) ? la_ff : PB'(1)) : '0;
      end
      if (cmd.mul_step) begin
         if (cmd.mul_last) begin
            acc_ff <= '0;
            if (cmd.mul_sel) tb_ff <= acc_in;
            else             ta_ff <= acc_in;
         end else begin
            acc_ff <= acc_in;
         end
      end
      if (cmd.div_load) begin
         rem_ff <= RW'(num) << FRAC_BITS;
         d_ff   <= RW'(den) << FRAC_BITS;
      end
      if (cmd.div_step) begin
         d_ff <= d_ff >> 1;
         if (rem_ff >= d_ff) begin
            rem_ff <= rem_ff - d_ff;
            q_ff   <= {q_ff[FRAC_BITS-1:0], 1'b1};
         end else begin
            q_ff   <= {q_ff[FRAC_BITS-1:0], 1'b0};
         end
      end
   end

   assign rsp_asymmetry = q_ff;
   assign rsp_status    = status_ff;

endmodule

>>> rtl/vertex_deposition_asymmetry.sv
// Vertex deposition asymmetry.
// Requests arrive on req_* (valid/stall); each carries one hit or an empty
// marker. Hits are projected on the configured axis about the configured
// vertex and summed per side. A request with last_hit set produces one
// result on rsp_* (valid/stall); other requests produce none.
// Hits are taken one per cycle while req_stall is low: a two-stage path
// (products, then accumulate) sets that rate. After a last request the
// input stalls for the closing sequence: finish accumulating, form lengths
// and choose the metric; then, when a ratio is needed, run the shift-add
// multiplier for the two cross terms and the restoring divider, else go
// straight to the result. The input stays stalled while the result waits;
// the result holds until rsp_stall is low, then the side sums are cleared
// and requests are taken again.
// csr_* writes registers by index (0 use_energy_metric, 1 vertex_x,
// 2 vertex_z, 3 axis_x, 4 axis_z); csr_ready is always high. Write only
// while idle. Reset restores register defaults and clears the sums.
module vertex_deposition_asymmetry #(
   parameter int MAX_HITS    = vda_pkg::DEF_MAX_HITS,
   parameter int POS_BITS    = vda_pkg::DEF_POS_BITS,
   parameter int ENERGY_BITS = vda_pkg::DEF_ENERGY_BITS,
   parameter int FRAC_BITS   = vda_pkg::DEF_FRAC_BITS,
   parameter int CSR_BITS    = (POS_BITS > vda_pkg::AXIS_BITS) ? POS_BITS : vda_pkg::AXIS_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [vda_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]              csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_hit_present,
   input  logic signed [POS_BITS-1:0]       req_hit_x,
   input  logic signed [POS_BITS-1:0]       req_hit_z,
   input  logic [ENERGY_BITS-1:0]           req_hit_energy,
   input  logic                             req_last_hit,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [FRAC_BITS:0]               rsp_asymmetry,
   output logic [1:0]                       rsp_status
);

   vda_pkg::cmd_type  cmd;
   vda_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   vda_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   vda_datapath #(
      .MAX_HITS    (MAX_HITS),
      .POS_BITS    (POS_BITS),
      .ENERGY_BITS (ENERGY_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .CSR_BITS    (CSR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_hit_present (req_hit_present),
      .req_hit_x       (req_hit_x),
      .req_hit_z       (req_hit_z),
      .req_hit_energy  (req_hit_energy),
      .req_last_hit    (req_last_hit),
      .rsp_asymmetry   (rsp_asymmetry),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

>>> rtl/vda_checker.sv
module vda_checker #(
   parameter int FRAC_BITS = vda_pkg::DEF_FRAC_BITS
) (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [FRAC_BITS:0] rsp_asymmetry,
   input logic [1:0]         rsp_status
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while result pending");

   a_zero_cases: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == vda_pkg::STAT_DEGEN ||
                    rsp_status == vda_pkg::STAT_NO_HITS) |-> rsp_asymmetry == '0)
      else $error("nonzero asymmetry without a metric");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_asymmetry <= ((FRAC_BITS+1)'(1) << FRAC_BITS))
      else $error("asymmetry above one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_asymmetry) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind vertex_deposition_asymmetry vda_checker #(.FRAC_BITS(FRAC_BITS)) u_vda_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_asymmetry (rsp_asymmetry),
   .rsp_status    (rsp_status)
);

>>> bench/vertex_deposition_asymmetry_test.sv
`timescale 1ns / 1ps

class asym_scoreboard;
   bit                 use_energy;
   longint             vtx_x, vtx_z, ax_x, ax_z;
   longint unsigned    e_before, e_after, n_before, n_after;
   longint             min_before, max_before, min_after, max_after;
   bit [16:0]          exp_asym[$];
   bit [1:0]           exp_status[$];
   int                 errors;
   int                 results_seen;
   int                 status_seen[4];

   function void clear_event();
      longint pmax;
      pmax = (longint'(1) << 37) - 1;
      e_before = 0; e_after = 0; n_before = 0; n_after = 0;
      min_before = pmax; max_before = -pmax - 1;
      min_after = pmax; max_after = -pmax - 1;
   endfunction

   function void reset_state();
      use_energy = 1; vtx_x = 0; vtx_z = 0; ax_x = 0; ax_z = 0;
      clear_event();
   endfunction

   function void write_reg(bit [2:0] idx, bit [19:0] data);
      case (idx)
         vda_pkg::REG_USE_ENERGY: use_energy = data[0];
         vda_pkg::REG_VERTEX_X:   vtx_x = longint'($signed(data));
         vda_pkg::REG_VERTEX_Z:   vtx_z = longint'($signed(data));
         vda_pkg::REG_AXIS_X:     ax_x = longint'($signed(data[15:0]));
         vda_pkg::REG_AXIS_Z:     ax_z = longint'($signed(data[15:0]));
         default: ;
      endcase
   endfunction

   // floor(2^16 * |ta - tb| / (ta + tb))
   function bit [16:0] ratio(bit [127:0] ta, bit [127:0] tb);
      bit [127:0] num, den;
      num = (ta >= tb) ? ta - tb : tb - ta;
      den = ta + tb;
      return 17'((num << 16) / den);
   endfunction

   function void note_request(bit present, bit [19:0] hx, bit [19:0] hz, bit [15:0] en,
                              bit last);
      longint          p;
      longint unsigned lb, la;
      bit              e_live, h_live;
      bit [127:0]      ta, tb;
      bit [16:0]       asym;
      bit [1:0]        st;
      longint unsigned smax, cmax;
      smax = (64'd1 << 28) - 1;
      cmax = (64'd1 << 13) - 1;
      if (present && n_before + n_after < 4096) begin
         p = (longint'($signed(hx)) - vtx_x) * ax_x + (longint'($signed(hz)) - vtx_z) * ax_z;
         if (p < 0) begin
            if (p < min_before) min_before = p;
            if (p > max_before) max_before = p;
            e_before = (smax - e_before < en) ? smax : e_before + en;
            if (n_before < cmax) n_before++;
         end else begin
            if (p < min_after) min_after = p;
            if (p > max_after) max_after = p;
            e_after = (smax - e_after < en) ? smax : e_after + en;
            if (n_after < cmax) n_after++;
         end
      end
      if (!last) return;
      lb = n_before ? longint'(max_before - min_before) : 0;
      la = n_after ? longint'(max_after - min_after) : 0;
      e_live = (la != 0 && e_after != 0) || (lb != 0 && e_before != 0);
      h_live = (la != 0 && n_after != 0) || (lb != 0 && n_before != 0);
      asym = 0;
      if (use_energy && e_live) begin
         ta = la ? 128'(e_after) * 128'(lb ? lb : 1) : 0;
         tb = lb ? 128'(e_before) * 128'(la ? la : 1) : 0;
         asym = ratio(ta, tb);
         st = vda_pkg::STAT_ENERGY;
      end else if (n_before + n_after == 0) begin
         st = vda_pkg::STAT_NO_HITS;
      end else if (h_live) begin
         ta = la ? 128'(n_after) * 128'(lb ? lb : 1) : 0;
         tb = lb ? 128'(n_before) * 128'(la ? la : 1) : 0;
         asym = ratio(ta, tb);
         st = vda_pkg::STAT_HITS;
      end else begin
         st = vda_pkg::STAT_DEGEN;
      end
      exp_asym.push_back(asym);
      exp_status.push_back(st);
      clear_event();
   endfunction

   function void check_result(bit [16:0] asym, bit [1:0] st);
      bit [16:0] ea;
      bit [1:0]  es;
      results_seen++;
      status_seen[st]++;
      if (exp_asym.size() == 0) begin
         $display("%0t: unexpected result asymmetry %0d status %0d", $time, asym, st);
         errors++;
         return;
      end
      ea = exp_asym.pop_front();
      es = exp_status.pop_front();
      if (ea !== asym) begin
         $display("%0t: asymmetry expected %0d actual %0d", $time, ea, asym);
         errors++;
      end
      if (es !== st) begin
         $display("%0t: status expected %0d actual %0d", $time, es, st);
         errors++;
      end
   endfunction
endclass

module vertex_deposition_asymmetry_test;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [19:0] csr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_hit_present = 0;
   logic [19:0] req_hit_x = 0;
   logic [19:0] req_hit_z = 0;
   logic [15:0] req_hit_energy = 0;
   logic        req_last_hit = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [16:0] rsp_asymmetry;
   logic [1:0]  rsp_status;

   asym_scoreboard sb;
   bit  idle_enable = 1;
   bit  finished = 0;
   int  quiet_cycles = 0;
   int  requests_sent = 0;

   always #5 clock = ~clock;

   vertex_deposition_asymmetry uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_hit_present(req_hit_present),
      .req_hit_x(req_hit_x), .req_hit_z(req_hit_z), .req_hit_energy(req_hit_energy),
      .req_last_hit(req_last_hit),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_asymmetry(rsp_asymmetry),
      .rsp_status(rsp_status)
   );

   // result side: check and stall in bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_asymmetry, rsp_status);
      end
   end

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 14);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || finished)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == 20000) begin
         $display("timeout with %0d results outstanding", sb.exp_asym.size());
         $display("vertex_deposition_asymmetry regression: fail");
         $finish;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [19:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      csr_valid <= 0;
   endtask

   task automatic send_hit(bit present, bit [19:0] hx, bit [19:0] hz, bit [15:0] en,
                           bit last);
      int n;
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 14);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid       <= 1;
      req_hit_present <= present;
      req_hit_x       <= hx;
      req_hit_z       <= hz;
      req_hit_energy  <= en;
      req_last_hit    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(present, hx, hz, en, last);
      requests_sent++;
   endtask

   // hold off until every result is back, then let the block settle
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.exp_asym.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic bit [19:0] rand_pos();
      case ($urandom_range(0, 4))
         0: return 20'h80000;
         1: return 20'h7FFFF;
         2: return 20'($urandom_range(0, 255)) - 20'd128;
         default: return 20'($urandom);
      endcase
   endfunction

   function automatic bit [15:0] rand_energy();
      case ($urandom_range(0, 3))
         0: return 16'hFFFF;
         1: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_event(int len);
      for (int i = 0; i < len; i++)
         send_hit($urandom_range(0, 9) != 0, rand_pos(), rand_pos(), rand_energy(),
                  i == len - 1);
   endtask

   task automatic random_config();
      write_csr(vda_pkg::REG_USE_ENERGY, 20'($urandom_range(0, 1)));
      write_csr(vda_pkg::REG_VERTEX_X, rand_pos());
      write_csr(vda_pkg::REG_VERTEX_Z, rand_pos());
      case ($urandom_range(0, 3))
         0: begin write_csr(vda_pkg::REG_AXIS_X, 20'h08000);
                  write_csr(vda_pkg::REG_AXIS_Z, 20'h07FFF); end
         1: begin write_csr(vda_pkg::REG_AXIS_X, 20'($urandom_range(0, 6)) - 20'd3);
                  write_csr(vda_pkg::REG_AXIS_Z, 20'($urandom_range(0, 6)) - 20'd3); end
         default: begin write_csr(vda_pkg::REG_AXIS_X, 20'($urandom));
                  write_csr(vda_pkg::REG_AXIS_Z, 20'($urandom)); end
      endcase
      // out of range index: ignored
      write_csr(3'd7, 20'($urandom));
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero axis, all after, degenerate
      send_hit(1, 20'd5, 20'd5, 16'd100, 1);
      // no hits at all
      send_hit(0, 20'd0, 20'd0, 16'd0, 1);
      drain();
      write_csr(vda_pkg::REG_AXIS_X, 20'd1);
      write_csr(vda_pkg::REG_AXIS_Z, 20'd0);
      // energy metric, both sides
      send_hit(1, 20'hFFFF0, 20'd0, 16'hFFFF, 0);
      send_hit(1, 20'hFFF00, 20'd0, 16'd10, 0);
      send_hit(1, 20'd3, 20'd0, 16'd0, 0);
      send_hit(1, 20'd90, 20'd0, 16'd500, 1);
      // extremes of position, zero energy everywhere falls back to hits
      send_hit(1, 20'h80000, 20'h7FFFF, 16'd0, 0);
      send_hit(1, 20'h7FFFF, 20'h80000, 16'd0, 0);
      send_hit(1, 20'd1, 20'd1, 16'd0, 1);
      drain();
      write_csr(vda_pkg::REG_USE_ENERGY, 20'd0);
      write_csr(vda_pkg::REG_VERTEX_X, 20'h7FFFF);
      write_csr(vda_pkg::REG_VERTEX_Z, 20'h80000);
      write_csr(vda_pkg::REG_AXIS_X, 20'h08000);
      write_csr(vda_pkg::REG_AXIS_Z, 20'h07FFF);
      send_hit(1, 20'h80000, 20'h7FFFF, 16'hFFFF, 0);
      send_hit(1, 20'h7FFFF, 20'h80000, 16'hFFFF, 0);
      send_hit(1, 20'h00000, 20'h00000, 16'hFFFF, 1);
      // empty event in hit-only mode
      send_hit(0, 20'h7FFFF, 20'h80000, 16'hFFFF, 1);
      drain();
      write_csr(vda_pkg::REG_USE_ENERGY, 20'd1);
      write_csr(vda_pkg::REG_VERTEX_X, 20'd0);
      write_csr(vda_pkg::REG_VERTEX_Z, 20'd0);
      write_csr(vda_pkg::REG_AXIS_X, 20'd1);
      write_csr(vda_pkg::REG_AXIS_Z, 20'd1);
      // a long event at full energy
      for (int i = 0; i < 200; i++)
         send_hit(1, 20'(i), 20'd0, 16'hFFFF, i == 199);
      drain();

      // random phases
      while (requests_sent < 650) begin
         random_config();
         repeat ($urandom_range(3, 8)) random_event($urandom_range(1, 12));
         if (requests_sent > 520) idle_enable = 0;
         drain();
      end

      finished = 1;
      $display("covered %0d requests, %0d results (energy %0d, hits %0d, degenerate %0d, none %0d)",
               requests_sent, sb.results_seen, sb.status_seen[0], sb.status_seen[1],
               sb.status_seen[2], sb.status_seen[3]);
      if (sb.errors == 0 && sb.exp_asym.size() == 0)
         $display("vertex_deposition_asymmetry regression: pass");
      else
         $display("vertex_deposition_asymmetry regression: fail");
      $finish;
   end
endmodule
